FILE: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants of the double-ended queue unit
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEQ_DEPTH     = 16;
    localparam int DEQ_WORD_BITS = 32;

    // fixed widths of the stream fields
    localparam int REPORT_BITS   = 32;
    localparam int COUNT_BITS    = 5;
    localparam int S_TDATA_BITS  = 32;
    localparam int S_TUSER_BITS  = 2;
    localparam int M_FIELD_BITS  = 2 * REPORT_BITS + COUNT_BITS;
    localparam int M_TDATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_PAD   = M_TDATA_BITS - M_FIELD_BITS;
    localparam int M_TUSER_BITS  = 3;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

FILE: sv/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: sv/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded deque of signed words kept as a ring in one memory
// ----------------------------------------------------------------------------
// order: an accepted input beat steps the unit through S_READ and S_LOAD, and the
//   result register is loaded in S_LOAD; a new input beat is taken only in S_IDLE,
//   after the ring memory write and its registered read of the new front and back
//   words, and S_LOAD holds while an earlier result beat still waits for m_tready
// reset: front index and held count clear to zero, ring memory is not cleared
//   (only entries that hold queued words are ever reported)
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
    parameter int DEPTH     = deq_pkg::DEQ_DEPTH,
    parameter int WORD_BITS = deq_pkg::DEQ_WORD_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [deq_pkg::S_TDATA_BITS-1:0] s_tdata,   // [31:0] value
    input  logic [deq_pkg::S_TUSER_BITS-1:0] s_tuser,   // [1:0] kind
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [deq_pkg::M_TDATA_BITS-1:0] m_tdata,   // [31:0] front_value,
                                                        // [63:32] back_value,
                                                        // [68:64] count, rest zero
    output logic [deq_pkg::M_TUSER_BITS-1:0] m_tuser    // [1:0] status, [2] is_empty
);

    import deq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } state_t;

    // ring control state
    state_t               state_reg;
    logic [IDX_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    status_t              st_reg, st_next;

    // output register
    logic                   m_valid_reg;
    status_t                m_status_reg;
    logic [REPORT_BITS-1:0] m_front_reg;
    logic [REPORT_BITS-1:0] m_back_reg;
    logic [COUNT_BITS-1:0]  m_count_reg;
    logic                   m_empty_reg;

    // memory ports
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [WORD_BITS-1:0] wr_word;
    logic [IDX_W-1:0]     back_addr;
    logic [WORD_BITS-1:0] front_word;
    logic [WORD_BITS-1:0] back_word;

    // ring position arithmetic
    logic [SUM_W-1:0]     tail_sum;    // front + count, slot after the back
    logic [SUM_W-1:0]     back_sum;    // front + count - 1
    logic [IDX_W-1:0]     tail_addr;
    logic [IDX_W-1:0]     front_dec;
    logic [IDX_W-1:0]     front_inc;

    logic    accept;
    logic    full;
    logic    empty;
    kind_t   kind_in;
    logic    out_free;

    assign kind_in  = kind_t'(s_tuser[1:0]);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign out_free = !m_valid_reg || m_tready;

    // pushed word is truncated or sign-extended to the stored width
    assign wr_word  = WORD_BITS'($signed(s_tdata[31:0]));

    always_comb begin
        // sums stay below twice the depth, so one compare and subtract wraps them
        tail_sum = SUM_W'(front_reg) + SUM_W'(cnt_reg);
        if (tail_sum >= SUM_W'(DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(DEPTH);
        end
        tail_addr = IDX_W'(tail_sum);

        back_sum = SUM_W'(front_reg) + SUM_W'(cnt_reg) - SUM_W'(1);
        if (empty) begin
            back_sum = SUM_W'(front_reg);
        end else if (back_sum >= SUM_W'(DEPTH)) begin
            back_sum = back_sum - SUM_W'(DEPTH);
        end
        back_addr = IDX_W'(back_sum);

        front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);
        front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + IDX_W'(1);
    end

    // operation decode: new front, new count, status and the ring write
    always_comb begin
        front_next = front_reg;
        cnt_next   = cnt_reg;
        st_next    = ST_DONE;
        wr_en      = 1'b0;
        wr_addr    = tail_addr;
        unique case (kind_in)
            KIND_PUSH_FRONT: begin
                if (full) begin
                    st_next = ST_FULL;
                end else begin
                    front_next = front_dec;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    wr_en      = accept;
                    wr_addr    = front_dec;
                end
            end
            KIND_PUSH_BACK: begin
                if (full) begin
                    st_next = ST_FULL;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    wr_en    = accept;
                end
            end
            KIND_POP_FRONT: begin
                if (empty) begin
                    st_next = ST_EMPTY;
                end else begin
                    front_next = front_inc;
                    cnt_next   = cnt_reg - CNT_W'(1);
                end
            end
            KIND_POP_BACK: begin
                if (empty) begin
                    st_next = ST_EMPTY;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default: begin
                st_next = ST_DONE;
            end
        endcase
    end

    // read ports always follow the current front and back, so the words
    // for the new state are in the read registers by S_LOAD
    deq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_word),
        .rd_addr_a (front_reg),
        .rd_data_a (front_word),
        .rd_addr_b (back_addr),
        .rd_data_b (back_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            cnt_reg     <= '0;
            st_reg      <= ST_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            // a waiting beat leaves unless a new one is loaded in its place
            if (m_tready && !(state_reg == S_LOAD && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        front_reg <= front_next;
                        cnt_reg   <= cnt_next;
                        st_reg    <= st_next;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    // read of the updated ring positions is in flight
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= st_reg;
                        m_count_reg  <= COUNT_BITS'(cnt_reg);
                        m_empty_reg  <= empty;
                        if (empty) begin
                            m_front_reg <= '1;
                            m_back_reg  <= '1;
                        end else begin
                            // stored word is sign-extended to the report width
                            m_front_reg <= REPORT_BITS'($signed(front_word));
                            m_back_reg  <= REPORT_BITS'($signed(back_word));
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_TDATA_PAD{1'b0}}, m_count_reg, m_back_reg, m_front_reg};
    assign m_tuser  = {m_empty_reg, m_status_reg};

    // held count never passes the ring depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("held count beyond depth");

    // a refused push is only reported on a full ring
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ && st_reg == ST_FULL) |-> cnt_reg == CNT_W'(DEPTH))
        else $error("full status with free slots");

    // an accepted push into a ring with room grows the count by one
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !full && (kind_in == KIND_PUSH_FRONT || kind_in == KIND_PUSH_BACK))
        |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("push did not grow the count");

    // an empty result reports -1 at both ends
    a_empty_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_empty_reg) |-> (m_front_reg == '1 && m_back_reg == '1))
        else $error("empty result with stale words");

endmodule
